[hw/rtl/mbc1_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbc1_pkg
// Types, codes and helpers shared by the MBC1 bank controller.
// ----------------------------------------------------------------------------
package mbc1_pkg;

  localparam int unsigned RAM_BANKS_MAX  = 4;
  localparam int unsigned RAM_BANK_BYTES = 8192;
  localparam int unsigned ROM_BANK_BYTES = 16384;

  localparam int unsigned RAM_BANK_W = $clog2(RAM_BANKS_MAX);
  localparam int unsigned RAM_OFF_W  = $clog2(RAM_BANK_BYTES);
  localparam int unsigned ROM_OFF_W  = $clog2(ROM_BANK_BYTES);
  localparam int unsigned RAM_IDX_W  = RAM_BANK_W + RAM_OFF_W;
  localparam int unsigned RAM_DEPTH  = RAM_BANKS_MAX * RAM_BANK_BYTES;

  localparam int unsigned ROM_BANK_W = 7;
  localparam int unsigned ROM_ADDR_W = 21;

  // Register window boundaries on the CPU bus
  localparam logic [15:0] ADDR_BANK_LO  = 16'h2000;
  localparam logic [15:0] ADDR_BANK_HI  = 16'h4000;
  localparam logic [15:0] ADDR_MODE     = 16'h6000;
  localparam logic [15:0] ADDR_ROM_END  = 16'h8000;

  localparam logic [3:0] RAM_EN_KEY = 4'hA;
  localparam logic [7:0] OPEN_BUS   = 8'hFF;

  typedef enum logic [1:0] {
    KIND_ROM_RD = 2'd0,
    KIND_ROM_WR = 2'd1,
    KIND_RAM_RD = 2'd2,
    KIND_RAM_WR = 2'd3
  } kind_t;

  typedef enum logic [0:0] {
    CFG_ROM_BANKS = 1'b0,
    CFG_RAM_BANKS = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } in_item_t;

  typedef struct packed {
    logic                  rom_fetch;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic [7:0]            read_data;
  } out_item_t;

  // Mask of the largest power of two not above the count, capped at 128 banks
  function automatic logic [ROM_BANK_W-1:0] rom_mask(input logic [7:0] cnt);
    logic [ROM_BANK_W-1:0] m;
    m = '0;
    for (int i = 1; i < 8; i++) begin
      if (cnt[i]) begin
        m = ROM_BANK_W'((1 << i) - 1);
      end
    end
    return m;
  endfunction

  function automatic logic [RAM_BANK_W-1:0] ram_mask(input logic [2:0] cnt);
    logic [RAM_BANK_W-1:0] m;
    priority if (cnt[2]) begin
      m = 2'd3;
    end else if (cnt[1]) begin
      m = 2'd1;
    end else begin
      m = 2'd0;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/mbc1_bank_controller_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbc1_bank_controller_unit
// MBC1 cartridge bank controller: bank registers, ROM address mapping and
// a 32 KiB banked cartridge RAM.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  in_      | input     | in_valid / in_stall  | kind, addr, wdata
//  out_     | output    | out_valid / out_stall| rom_fetch, rom_address, read_data
//  cfg_     | input     | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
//  One item per cycle while no result is stalled, its result in the next cycle;
//  the single RAM port serves one read or one write per item at the acceptance edge.
//  Bank registers update at the acceptance edge, so the next item sees them.
//  Synchronous reset sets the switchable ROM bank to one and clears the other bank
//  registers; the RAM is not cleared. A stalled result holds the output stage and stalls the input.
// ----------------------------------------------------------------------------
module mbc1_bank_controller_unit (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire  mbc1_pkg::in_item_t  in_item,
  output logic                      out_valid,
  input  wire                       out_stall,
  output mbc1_pkg::out_item_t       out_item,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire  [0:0]                cfg_index,
  input  wire  [7:0]                cfg_wdata
);

  // configuration
  logic [7:0] rom_cnt_r;
  logic [2:0] ram_cnt_r;

  // bank registers
  logic                              ram_en_r, ram_en_nxt;
  logic                              mode_r, mode_nxt;
  logic [mbc1_pkg::ROM_BANK_W-1:0]   sw_bank_r, sw_bank_nxt;
  logic [mbc1_pkg::ROM_BANK_W-1:0]   low_bank_r, low_bank_nxt;
  logic [mbc1_pkg::RAM_BANK_W-1:0]   ram_bank_r, ram_bank_nxt;

  // result stage
  logic                              s1_valid_r;
  logic                              s1_fetch_r;
  logic [mbc1_pkg::ROM_ADDR_W-1:0]   s1_raddr_r;
  logic [7:0]                        s1_data_r;
  logic                              s1_use_ram_r;
  logic [7:0]                        ram_q_r;

  logic [7:0] ram_mem [mbc1_pkg::RAM_DEPTH];

  logic                              accept;
  logic [mbc1_pkg::ROM_BANK_W-1:0]   rmask;
  logic [mbc1_pkg::RAM_BANK_W-1:0]   bmask;
  logic [mbc1_pkg::RAM_BANK_W-1:0]   hi;
  logic [mbc1_pkg::RAM_BANK_W-1:0]   hi_bank;
  logic [mbc1_pkg::RAM_IDX_W-1:0]    ram_idx;
  logic                              fetch_d;
  logic [mbc1_pkg::ROM_ADDR_W-1:0]   raddr_d;
  logic [7:0]                        data_d;
  logic                              ram_rd;
  logic                              ram_wr;

  assign in_stall  = s1_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign rmask   = mbc1_pkg::rom_mask(rom_cnt_r);
  assign bmask   = mbc1_pkg::ram_mask(ram_cnt_r);
  assign ram_idx = {ram_bank_r, in_item.addr[mbc1_pkg::RAM_OFF_W-1:0]};
  assign ram_rd  = accept && (in_item.kind == mbc1_pkg::KIND_RAM_RD) && ram_en_r;
  assign ram_wr  = accept && (in_item.kind == mbc1_pkg::KIND_RAM_WR) && ram_en_r;
  assign hi      = in_item.wdata[1:0];
  assign hi_bank = (ram_cnt_r != 3'd0) ? (sw_bank_r[6:5] & bmask) : sw_bank_r[6:5];

  // bank register writes
  always_comb begin
    ram_en_nxt   = ram_en_r;
    mode_nxt     = mode_r;
    sw_bank_nxt  = sw_bank_r;
    low_bank_nxt = low_bank_r;
    ram_bank_nxt = ram_bank_r;
    if (accept && (in_item.kind == mbc1_pkg::KIND_ROM_WR)) begin
      priority if (in_item.addr < mbc1_pkg::ADDR_BANK_LO) begin
        if (ram_cnt_r != 3'd0) begin
          ram_en_nxt = (in_item.wdata[3:0] == mbc1_pkg::RAM_EN_KEY);
        end
      end else if (in_item.addr < mbc1_pkg::ADDR_BANK_HI) begin
        // a zero low field selects bank one
        if (in_item.wdata[4:0] == 5'd0) begin
          sw_bank_nxt = {sw_bank_r[6:5], 5'd1} & rmask;
        end else begin
          sw_bank_nxt = {sw_bank_r[6:5], in_item.wdata[4:0]} & rmask;
        end
      end else if (in_item.addr < mbc1_pkg::ADDR_MODE) begin
        sw_bank_nxt  = {hi, sw_bank_r[4:0]} & rmask;
        low_bank_nxt = mode_r ? ({hi, 5'd0} & rmask) : '0;
        if (!mode_r) begin
          ram_bank_nxt = '0;
        end else if (ram_cnt_r != 3'd0) begin
          ram_bank_nxt = hi & bmask;
        end else begin
          ram_bank_nxt = hi;
        end
      end else if (in_item.addr < mbc1_pkg::ADDR_ROM_END) begin
        mode_nxt = in_item.wdata[0];
        if (in_item.wdata[0]) begin
          low_bank_nxt = {sw_bank_r[6:5], 5'd0};
          ram_bank_nxt = hi_bank;
        end else begin
          low_bank_nxt = '0;
          ram_bank_nxt = '0;
        end
      end else begin
        ram_en_nxt = ram_en_r;
      end
    end
  end

  // result for ROM reads, writes and disabled RAM
  always_comb begin
    fetch_d = 1'b0;
    raddr_d = '0;
    data_d  = 8'h00;
    unique case (in_item.kind)
      mbc1_pkg::KIND_ROM_RD: begin
        priority if (in_item.addr < mbc1_pkg::ADDR_BANK_HI) begin
          fetch_d = 1'b1;
          raddr_d = {low_bank_r, in_item.addr[mbc1_pkg::ROM_OFF_W-1:0]};
        end else if (in_item.addr < mbc1_pkg::ADDR_ROM_END) begin
          fetch_d = 1'b1;
          raddr_d = {sw_bank_r, in_item.addr[mbc1_pkg::ROM_OFF_W-1:0]};
        end else begin
          data_d = mbc1_pkg::OPEN_BUS;
        end
      end
      mbc1_pkg::KIND_RAM_RD: begin
        data_d = mbc1_pkg::OPEN_BUS;
      end
      default: begin
        data_d = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_cnt_r <= 8'd2;
      ram_cnt_r <= 3'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mbc1_pkg::CFG_ROM_BANKS: rom_cnt_r <= cfg_wdata;
        mbc1_pkg::CFG_RAM_BANKS: ram_cnt_r <= cfg_wdata[2:0];
        default:                 rom_cnt_r <= rom_cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_en_r   <= 1'b0;
      mode_r     <= 1'b0;
      sw_bank_r  <= 7'd1;
      low_bank_r <= '0;
      ram_bank_r <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      ram_en_r   <= ram_en_nxt;
      mode_r     <= mode_nxt;
      sw_bank_r  <= sw_bank_nxt;
      low_bank_r <= low_bank_nxt;
      ram_bank_r <= ram_bank_nxt;
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (!out_stall) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_fetch_r   <= fetch_d;
      s1_raddr_r   <= raddr_d;
      s1_data_r    <= data_d;
      s1_use_ram_r <= ram_rd;
    end
  end

  // cartridge RAM, one access per item
  always_ff @(posedge clk) begin
    if (ram_wr) begin
      ram_mem[ram_idx] <= in_item.wdata;
    end
    if (ram_rd) begin
      ram_q_r <= ram_mem[ram_idx];
    end
  end

  assign out_valid            = s1_valid_r;
  assign out_item.rom_fetch   = s1_fetch_r;
  assign out_item.rom_address = s1_raddr_r;
  assign out_item.read_data   = s1_use_ram_r ? ram_q_r : s1_data_r;

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted item produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !(out_valid && out_stall))
    else $error("item accepted over a stalled result");

  a_no_fetch_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.rom_fetch) |-> (out_item.rom_address == '0))
    else $error("ROM address set without fetch");

  a_mode0_banks_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !mode_r |-> (low_bank_r == '0 && ram_bank_r == '0))
    else $error("zero bank or RAM bank set in mode 0");

  a_ram_read_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.kind == mbc1_pkg::KIND_RAM_RD && !ram_en_r) |=>
      (out_item.read_data == mbc1_pkg::OPEN_BUS))
    else $error("disabled RAM read did not return open bus");
`endif

endmodule
`default_nettype wire

[dv/testbench.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Checks the MBC1 bank controller against a cycle-free predictor of its bank
// registers, ROM address mapping and banked RAM. Directed accesses hit the
// address and data extremes first, then phases of random bus traffic run under
// a range of ROM/RAM bank counts with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [15:0] RAM_WINDOW     = 16'hA000;
  localparam int          PHASE_COUNT    = 10;
  localparam int          PHASE_ITEMS    = 165;
  localparam int          LONG_HOLD      = 90;
  localparam int          WATCHDOG_LIMIT = 4000;

  localparam logic [0:PHASE_COUNT-1][7:0] ROM_SETTING =
    {8'd2, 8'd128, 8'd4, 8'd16, 8'd128, 8'd64, 8'd8, 8'd32, 8'd2, 8'd128};
  localparam logic [0:PHASE_COUNT-1][2:0] RAM_SETTING =
    {3'd1, 3'd4, 3'd2, 3'd0, 3'd0, 3'd4, 3'd1, 3'd2, 3'd4, 3'd4};

  typedef struct packed {
    logic       ram_en;
    logic       mode;
    logic [6:0] sw_bank;
    logic [6:0] zero_bank;
    logic [1:0] ram_bank;
  } bank_regs_t;

  localparam bank_regs_t REGS_AT_RESET =
    '{ram_en: 1'b0, mode: 1'b0, sw_bank: 7'd1, zero_bank: 7'd0, ram_bank: 2'd0};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  mbc1_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  mbc1_pkg::out_item_t out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [0:0]          cfg_index = mbc1_pkg::CFG_ROM_BANKS;
  logic [7:0]          cfg_wdata = 8'd0;

  // Bank counts as currently programmed into the block
  logic [7:0]  rom_banks = 8'd2;
  logic [2:0]  ram_banks = 3'd0;

  bank_regs_t  model_regs;
  bank_regs_t  plan_regs;
  logic [7:0]  ram_image [mbc1_pkg::RAM_DEPTH];
  bit          ram_written [mbc1_pkg::RAM_DEPTH];
  logic [15:0] recent_ram [$];

  mbc1_pkg::in_item_t  pending [$];
  mbc1_pkg::out_item_t expected [$];
  int          items_open = 0;
  int          errors = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;
  bit          long_hold_req = 1'b0;

  mbc1_bank_controller_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [6:0] rom_bank_mask(input logic [7:0] cnt);
    int unsigned p;
    p = 1;
    while (p * 2 <= cnt && p < 128) begin
      p = p * 2;
    end
    return 7'(p - 1);
  endfunction

  function automatic logic [1:0] ram_bank_mask(input logic [2:0] cnt);
    if (cnt >= 3'd4) begin
      return 2'd3;
    end else if (cnt >= 3'd2) begin
      return 2'd1;
    end
    return 2'd0;
  endfunction

  function automatic logic [mbc1_pkg::RAM_IDX_W-1:0] ram_slot(
    input bank_regs_t r,
    input logic [15:0] a
  );
    logic [15:0] d;
    d = a - RAM_WINDOW;
    return {r.ram_bank, d[mbc1_pkg::RAM_OFF_W-1:0]};
  endfunction

  function automatic bank_regs_t after_reg_write(input bank_regs_t r,
                                                 input logic [15:0] a,
                                                 input logic [7:0] v);
    logic [6:0] rmask;
    logic [4:0] lo;
    logic [1:0] hi;
    rmask = rom_bank_mask(rom_banks);
    if (a < mbc1_pkg::ADDR_BANK_LO) begin
      // enable is dead when the cartridge carries no RAM
      if (ram_banks != 3'd0) begin
        r.ram_en = (v[3:0] == mbc1_pkg::RAM_EN_KEY);
      end
    end else if (a < mbc1_pkg::ADDR_BANK_HI) begin
      lo = (v[4:0] == 5'd0) ? 5'd1 : v[4:0];
      r.sw_bank = {r.sw_bank[6:5], lo} & rmask;
    end else if (a < mbc1_pkg::ADDR_MODE) begin
      hi = v[1:0];
      r.sw_bank = {hi, r.sw_bank[4:0]} & rmask;
      r.zero_bank = r.mode ? ({hi, 5'd0} & rmask) : 7'd0;
      r.ram_bank = r.mode ? hi : 2'd0;
      if (ram_banks != 3'd0) begin
        r.ram_bank = r.ram_bank & ram_bank_mask(ram_banks);
      end
    end else if (a < mbc1_pkg::ADDR_ROM_END) begin
      r.mode = v[0];
      if (v[0]) begin
        hi = r.sw_bank[6:5];
        r.zero_bank = {hi, 5'd0};
        r.ram_bank = hi;
        if (ram_banks != 3'd0) begin
          r.ram_bank = r.ram_bank & ram_bank_mask(ram_banks);
        end
      end else begin
        r.zero_bank = 7'd0;
        r.ram_bank = 2'd0;
      end
    end
    return r;
  endfunction

  // Work out the response to one accepted access and advance the bank state
  task automatic predict_access(input mbc1_pkg::in_item_t it);
    mbc1_pkg::out_item_t            r;
    logic [mbc1_pkg::RAM_IDX_W-1:0] idx;
    r = '0;
    idx = ram_slot(model_regs, it.addr);
    case (it.kind)
      mbc1_pkg::KIND_ROM_RD: begin
        if (it.addr < mbc1_pkg::ADDR_BANK_HI) begin
          r.rom_fetch = 1'b1;
          r.rom_address = {model_regs.zero_bank, it.addr[mbc1_pkg::ROM_OFF_W-1:0]};
        end else if (it.addr < mbc1_pkg::ADDR_ROM_END) begin
          r.rom_fetch = 1'b1;
          r.rom_address = {model_regs.sw_bank, it.addr[mbc1_pkg::ROM_OFF_W-1:0]};
        end else begin
          r.read_data = mbc1_pkg::OPEN_BUS;
        end
      end
      mbc1_pkg::KIND_ROM_WR: begin
        model_regs = after_reg_write(model_regs, it.addr, it.wdata);
      end
      mbc1_pkg::KIND_RAM_RD: begin
        r.read_data = model_regs.ram_en ? ram_image[idx] : mbc1_pkg::OPEN_BUS;
      end
      mbc1_pkg::KIND_RAM_WR: begin
        if (model_regs.ram_en) begin
          ram_image[idx] = it.wdata;
        end
      end
    endcase
    expected.push_back(r);
  endtask

  // Queue one access; the planning copy of the bank state keeps RAM reads
  // away from bytes that were never written
  task automatic queue_access(input mbc1_pkg::kind_t k, input logic [15:0] a,
                              input logic [7:0] v);
    mbc1_pkg::in_item_t             it;
    logic [mbc1_pkg::RAM_IDX_W-1:0] idx;
    idx = ram_slot(plan_regs, a);
    if (k == mbc1_pkg::KIND_RAM_RD && plan_regs.ram_en && !ram_written[idx]) begin
      k = mbc1_pkg::KIND_RAM_WR;
    end
    if (k == mbc1_pkg::KIND_RAM_WR && plan_regs.ram_en) begin
      ram_written[idx] = 1'b1;
      recent_ram.push_back(a);
      if (recent_ram.size() > 32) begin
        void'(recent_ram.pop_front());
      end
    end
    if (k == mbc1_pkg::KIND_ROM_WR) begin
      plan_regs = after_reg_write(plan_regs, a, v);
    end
    it.kind = k;
    it.addr = a;
    it.wdata = v;
    pending.push_back(it);
    items_open++;
  endtask

  task automatic queue_random_access();
    int unsigned pick;
    int unsigned region;
    logic [15:0] a;
    logic [7:0]  v;
    pick = $urandom_range(0, 99);
    a = 16'($urandom_range(0, 16'hFFFF));
    v = 8'($urandom_range(0, 255));
    if (pick < 22) begin
      if ($urandom_range(0, 4) != 0) begin
        a[15] = 1'b0;
      end
      queue_access(mbc1_pkg::KIND_ROM_RD, a, v);
    end else if (pick < 44) begin
      region = $urandom_range(0, 4);
      if (region < 4) begin
        a[15:13] = {1'b0, 2'(region)};
      end else begin
        a[15] = 1'b1;
      end
      if (region == 0 && $urandom_range(0, 3) != 0) begin
        v[3:0] = mbc1_pkg::RAM_EN_KEY;
      end
      queue_access(mbc1_pkg::KIND_ROM_WR, a, v);
    end else if (pick < 72) begin
      if ($urandom_range(0, 7) != 0) begin
        a[15:13] = 3'b101;
      end
      queue_access(mbc1_pkg::KIND_RAM_WR, a, v);
    end else begin
      if (recent_ram.size() != 0 && $urandom_range(0, 9) < 6) begin
        a = recent_ram[$urandom_range(0, recent_ram.size() - 1)];
      end else if ($urandom_range(0, 7) != 0) begin
        a[15:13] = 3'b101;
      end
      queue_access(mbc1_pkg::KIND_RAM_RD, a, v);
    end
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (items_open != 0);
  endtask

  // Call at a rising edge; leaves valid high for a following write
  task automatic write_cfg(input mbc1_pkg::cfg_idx_t idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    if (idx == mbc1_pkg::CFG_ROM_BANKS) begin
      rom_banks = val;
    end else begin
      ram_banks = val[2:0];
    end
  endtask

  task automatic set_banks(input logic [7:0] rom, input logic [2:0] ram);
    wait_drained();
    write_cfg(mbc1_pkg::CFG_ROM_BANKS, rom);
    write_cfg(mbc1_pkg::CFG_RAM_BANKS, {5'd0, ram});
    cfg_valid <= 1'b0;
  endtask

  task automatic check_result(input mbc1_pkg::out_item_t got);
    mbc1_pkg::out_item_t want;
    if (expected.size() == 0) begin
      $error("result with no access waiting: %p", got);
      errors++;
    end else begin
      want = expected.pop_front();
      items_open--;
      if (got.rom_fetch !== want.rom_fetch) begin
        $error("rom_fetch: expected %0h, got %0h", want.rom_fetch, got.rom_fetch);
        errors++;
      end
      if (got.rom_address !== want.rom_address) begin
        $error("rom_address: expected %0h, got %0h", want.rom_address, got.rom_address);
        errors++;
      end
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin : driver
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_access(in_item);
      end
      if (in_valid && in_stall) begin
        // hold the stalled item
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (!calm && pending.size() != 0 && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 13);
        in_valid <= 1'b0;
      end else if (pending.size() != 0) begin
        in_item <= pending.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_item);
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 13);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : sequencer
    int unsigned split;
    model_regs = REGS_AT_RESET;
    plan_regs = REGS_AT_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset counts: no RAM, two ROM banks
    queue_access(mbc1_pkg::KIND_ROM_RD, 16'h0000, 8'h00);
    queue_access(mbc1_pkg::KIND_ROM_RD, 16'h7FFF, 8'hFF);
    queue_access(mbc1_pkg::KIND_ROM_RD, 16'h8000, 8'h00);
    queue_access(mbc1_pkg::KIND_ROM_RD, 16'hFFFF, 8'hFF);
    queue_access(mbc1_pkg::KIND_ROM_WR, 16'h0000, 8'h0A);
    queue_access(mbc1_pkg::KIND_RAM_RD, 16'hA000, 8'h00);
    queue_access(mbc1_pkg::KIND_RAM_WR, 16'hBFFF, 8'hFF);
    queue_access(mbc1_pkg::KIND_ROM_WR, 16'h5FFF, 8'hFF);
    queue_access(mbc1_pkg::KIND_ROM_WR, 16'h6000, 8'h01);
    queue_access(mbc1_pkg::KIND_ROM_RD, 16'h3FFF, 8'h00);

    // Largest counts: RAM enable, bank zero forced to one, upper bits in mode 1
    set_banks(8'd128, 3'd4);
    queue_access(mbc1_pkg::KIND_ROM_WR, 16'h1FFF, 8'hFA);
    queue_access(mbc1_pkg::KIND_ROM_WR, 16'h2000, 8'h00);
    queue_access(mbc1_pkg::KIND_ROM_RD, 16'h4000, 8'h00);
    queue_access(mbc1_pkg::KIND_ROM_WR, 16'h3FFF, 8'hFF);
    queue_access(mbc1_pkg::KIND_ROM_WR, 16'h4000, 8'h03);
    queue_access(mbc1_pkg::KIND_ROM_RD, 16'h0000, 8'h00);
    queue_access(mbc1_pkg::KIND_RAM_WR, 16'h0000, 8'h5A);
    queue_access(mbc1_pkg::KIND_RAM_RD, 16'h0000, 8'h00);
    queue_access(mbc1_pkg::KIND_RAM_WR, 16'hFFFF, 8'hA5);
    queue_access(mbc1_pkg::KIND_RAM_RD, 16'hFFFF, 8'h00);
    queue_access(mbc1_pkg::KIND_ROM_WR, 16'h7FFF, 8'h00);
    queue_access(mbc1_pkg::KIND_ROM_WR, 16'h8000, 8'hFF);
    queue_access(mbc1_pkg::KIND_ROM_WR, 16'h1000, 8'h00);
    queue_access(mbc1_pkg::KIND_RAM_RD, 16'hA123, 8'h00);

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      set_banks(ROM_SETTING[ph], RAM_SETTING[ph]);
      if (ph == PHASE_COUNT - 1) begin
        calm = 1'b1;
      end
      split = $urandom_range(30, PHASE_ITEMS - 30);
      repeat (split) queue_random_access();
      if (ph == 2 || ph == 6) begin
        long_hold_req = 1'b1;
      end
      // pause the sender until every result is back
      wait_drained();
      repeat (PHASE_ITEMS - split) queue_random_access();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0 && expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
hw/rtl/mbc1_pkg.sv
hw/rtl/mbc1_bank_controller_unit.sv
dv/testbench.sv
